// File: sv/tet_pkg.sv
// tet_pkg: shared types and codes for the timed event table
// no dependencies
package tet_pkg;
	typedef enum logic [2:0] {
		CMD_TICK = 3'd0, CMD_ADD = 3'd1, CMD_REMOVE = 3'd2, CMD_PAUSE = 3'd3,
		CMD_RESUME = 3'd4, CMD_RUN = 3'd5, CMD_HALT = 3'd6, CMD_GO = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_FULL = 2'd1, ST_EXISTS = 2'd2, ST_BAD = 2'd3
	} status_t;

	localparam logic [15:0] THRESH_RESET = 16'd50;
	localparam logic [7:0] STEP_RESET = 8'd7;
	localparam int MAX_RESULTS = 16;
	localparam int CFG_THRESH = 0;
	localparam int CFG_STEP = 1;

	typedef struct packed {
		cmd_t cmd;
		logic [7:0] handler_id;
		logic is_timer;
		logic [15:0] repeat_count;
		logic [15:0] period_ms;
	} item_t;

	typedef struct packed {
		status_t status;
		logic fired;
		logic [7:0] fired_handler;
		logic last;
	} result_t;

	typedef enum logic [2:0] {
		EX_IDLE, EX_SCAN, EX_MOVE, EX_EMIT, EX_DONE
	} ex_state_t;
endpackage

// File: sv/tet_fifo.sv
// tet_fifo: small register queue used between front and back and on results
// depends on nothing
module tet_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic wr,
	input logic [W-1:0] wdata,
	output logic full,
	input logic rd,
	output logic [W-1:0] rdata,
	output logic empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	logic [W-1:0] mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic do_wr, do_rd;

	assign full = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (do_rd) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(do_wr) - (AW+1)'(do_rd);
		end
	end
endmodule

// File: sv/tet_exec.sv
// tet_exec: back part, walks the table one slot per cycle per command, held while it emits or moves an entry
// depends on tet_pkg
module tet_exec import tet_pkg::*; #(
	parameter int TABLE_SIZE = 16
) (
	input logic clk,
	input logic arst_n,
	input logic [15:0] thresh,
	input logic [7:0] step,
	input logic cmd_valid,
	input item_t cmd_item,
	output logic cmd_take,
	output logic res_push,
	output result_t res_item,
	input logic res_full
);
	localparam int IW = $clog2(TABLE_SIZE);
	localparam int CW = $clog2(TABLE_SIZE + 1);
	localparam int NW = $clog2(MAX_RESULTS + 1);

	logic [7:0] hnd_q [TABLE_SIZE];
	logic tmr_q [TABLE_SIZE];
	logic [15:0] rep_q [TABLE_SIZE];
	logic [15:0] per_q [TABLE_SIZE];
	logic [31:0] dl_q [TABLE_SIZE];
	logic [TABLE_SIZE-1:0] arm_q, pau_q, free_q;
	logic [CW-1:0] used_q;
	logic [31:0] now_q;
	logic run_q;

	ex_state_t st_q, st_d;
	item_t it_q;
	logic [CW-1:0] idx_q;
	logic [IW-1:0] gap_q, free_slot_q;
	logic found_q, free_found_q, rm_run_q;
	logic [NW-1:0] nfire_q;
	logic [7:0] emit_h_q;
	logic [7:0] pend_h_q;
	status_t stat_q;

	logic [IW-1:0] ix, lastx;
	logic in_rng, in_used, free_any;
	logic [IW-1:0] free_first;
	logic [IW-1:0] hit_first;
	logic [CW-1:0] used_m1;

	assign ix = idx_q[IW-1:0];
	assign in_rng = (idx_q < CW'(TABLE_SIZE));
	assign in_used = (idx_q < used_q) && in_rng;
	assign used_m1 = (used_q == '0) ? '0 : used_q - 1'b1;
	assign lastx = (used_m1 >= CW'(TABLE_SIZE)) ? IW'(TABLE_SIZE-1) : used_m1[IW-1:0];

	always_comb begin
		free_any = 1'b0;
		free_first = '0;
		for (int k = TABLE_SIZE - 1; k >= 0; k--) begin
			if (free_q[k]) begin
				free_any = 1'b1;
				free_first = IW'(k);
			end
		end
	end

	// first slot holding the handler just fired
	always_comb begin
		hit_first = '0;
		for (int k = TABLE_SIZE - 1; k >= 0; k--) begin
			if (hnd_q[k] == emit_h_q) hit_first = IW'(k);
		end
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			EX_IDLE: if (cmd_valid) st_d = EX_SCAN;
			EX_SCAN: begin
				priority if (it_q.cmd == CMD_RUN) begin
					if (!run_q || !in_used || nfire_q == NW'(MAX_RESULTS))
						st_d = EX_DONE;
					else if (arm_q[ix] && hnd_q[ix] != 8'd0 && !pau_q[ix])
						st_d = EX_EMIT;
				end else if (it_q.cmd == CMD_REMOVE) begin
					if (stat_q != ST_OK || found_q || !in_rng) st_d = EX_DONE;
					else if (hnd_q[ix] == it_q.handler_id) st_d = EX_MOVE;
				end else if (!in_rng) begin
					st_d = EX_DONE;
				end
			end
			EX_EMIT: if (!res_full) st_d = rm_run_q ? EX_MOVE : EX_SCAN;
			EX_MOVE: st_d = (it_q.cmd == CMD_RUN) ? EX_SCAN : EX_DONE;
			EX_DONE: if (!res_full) st_d = EX_IDLE;
			default: st_d = EX_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd_take = (st_q == EX_IDLE) && cmd_valid;
		res_push = 1'b0;
		res_item = '{status: ST_OK, fired: 1'b0, fired_handler: 8'd0, last: 1'b1};
		unique case (st_q)
			EX_EMIT: begin
				// the previous fired beat goes out once a later one is found
				res_push = !res_full && nfire_q != '0;
				res_item = '{status: ST_OK, fired: 1'b1, fired_handler: pend_h_q,
					last: 1'b0};
			end
			EX_DONE: begin
				res_push = !res_full;
				if (it_q.cmd == CMD_RUN && nfire_q != '0)
					res_item = '{status: ST_OK, fired: 1'b1, fired_handler: pend_h_q,
						last: 1'b1};
				else res_item.status = stat_q;
			end
			default: ;
		endcase
	end

	logic [31:0] add_dl;
	always_comb begin
		add_dl = now_q + 32'(it_q.period_ms);
		if (it_q.period_ms > thresh) add_dl = add_dl + 32'(free_slot_q) * 32'(step);
	end

	always_ff @(posedge clk) begin
		if (st_q == EX_IDLE && cmd_valid) it_q <= cmd_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= EX_IDLE;
			for (int k = 0; k < TABLE_SIZE; k++) begin
				hnd_q[k] <= '0; tmr_q[k] <= '0; rep_q[k] <= '0;
				per_q[k] <= '0; dl_q[k] <= '0;
			end
			arm_q <= '0; pau_q <= '0; free_q <= '1;
			used_q <= '0; now_q <= '0; run_q <= 1'b1;
			idx_q <= '0; gap_q <= '0; free_slot_q <= '0;
			found_q <= 1'b0; free_found_q <= 1'b0; rm_run_q <= 1'b0;
			nfire_q <= '0; emit_h_q <= '0; pend_h_q <= '0; stat_q <= ST_OK;
		end else begin
			st_q <= st_d;
			unique case (st_q)
				EX_IDLE: begin
					idx_q <= '0;
					found_q <= 1'b0;
					nfire_q <= '0;
					stat_q <= ST_OK;
					free_found_q <= free_any;
					free_slot_q <= free_first;
					if (cmd_valid) begin
						unique case (cmd_item.cmd)
							CMD_TICK: if (run_q) now_q <= now_q + 1'b1;
							CMD_ADD: begin
								if (cmd_item.handler_id == 8'd0) stat_q <= ST_BAD;
								else if (used_q + 1'b1 >= CW'(TABLE_SIZE)) stat_q <= ST_FULL;
							end
							CMD_REMOVE, CMD_PAUSE, CMD_RESUME:
								if (cmd_item.handler_id == 8'd0 || used_q == '0) stat_q <= ST_BAD;
							CMD_HALT: run_q <= 1'b0;
							CMD_GO: run_q <= 1'b1;
							default: ;
						endcase
					end
				end
				EX_SCAN: begin
					if (in_rng) idx_q <= idx_q + 1'b1;
					unique case (it_q.cmd)
						CMD_TICK: if (in_rng && run_q) begin
							if (dl_q[ix] <= now_q && rep_q[ix] != '0 && hnd_q[ix] != '0
								&& tmr_q[ix] && !arm_q[ix] && !pau_q[ix]) begin
								if (rep_q[ix] != '0 && !rep_q[ix][15]) rep_q[ix] <= rep_q[ix] - 1'b1;
								dl_q[ix] <= now_q + 32'(per_q[ix]);
								arm_q[ix] <= 1'b1;
							end
						end
						CMD_ADD: if (stat_q == ST_OK && in_rng) begin
							if (in_used && hnd_q[ix] == it_q.handler_id && arm_q[ix]) begin
								pau_q[ix] <= 1'b0;
								stat_q <= ST_EXISTS;
								idx_q <= CW'(TABLE_SIZE);
							end else if (!in_used) begin
								idx_q <= CW'(TABLE_SIZE);
								if (!free_found_q) stat_q <= ST_FULL;
								else begin
									hnd_q[free_slot_q] <= it_q.handler_id;
									tmr_q[free_slot_q] <= it_q.is_timer;
									rep_q[free_slot_q] <= it_q.repeat_count;
									per_q[free_slot_q] <= it_q.period_ms;
									if (it_q.is_timer) begin
										dl_q[free_slot_q] <= add_dl;
										arm_q[free_slot_q] <= 1'b0;
									end else arm_q[free_slot_q] <= 1'b1;
									free_q[free_slot_q] <= 1'b0;
									pau_q[free_slot_q] <= 1'b0;
									used_q <= used_q + 1'b1;
								end
							end
						end else idx_q <= CW'(TABLE_SIZE);
						CMD_REMOVE: begin
							if (stat_q != ST_OK) found_q <= 1'b1;
							else if (in_rng && hnd_q[ix] == it_q.handler_id) begin
								gap_q <= ix;
								emit_h_q <= it_q.handler_id;
							end
						end
						CMD_PAUSE, CMD_RESUME: if (stat_q == ST_OK && in_rng
							&& hnd_q[ix] == it_q.handler_id) begin
							if (it_q.cmd == CMD_PAUSE) pau_q[ix] <= 1'b1;
							else begin
								pau_q[ix] <= 1'b0;
								dl_q[ix] <= 32'(per_q[ix]) + now_q;
							end
						end
						CMD_RUN: if (run_q && in_used && nfire_q != NW'(MAX_RESULTS)
							&& arm_q[ix] && hnd_q[ix] != 8'd0 && !pau_q[ix]) begin
							emit_h_q <= hnd_q[ix];
							rm_run_q <= 1'b0;
							if (tmr_q[ix]) begin
								if (rep_q[ix] == '0) rm_run_q <= 1'b1;
								else arm_q[ix] <= 1'b0;
							end else begin
								idx_q <= idx_q;
								rm_run_q <= 1'b1;
								if (rep_q[ix] != '0 && !rep_q[ix][15]) rep_q[ix] <= rep_q[ix] - 1'b1;
							end
						end
						default: idx_q <= CW'(TABLE_SIZE);
					endcase
				end
				EX_EMIT: if (!res_full) begin
					nfire_q <= nfire_q + 1'b1;
					pend_h_q <= emit_h_q;
					if (rm_run_q) gap_q <= hit_first;
				end
				EX_MOVE: begin
					if (gap_q < lastx) begin
						hnd_q[gap_q] <= hnd_q[lastx]; tmr_q[gap_q] <= tmr_q[lastx];
						rep_q[gap_q] <= rep_q[lastx]; per_q[gap_q] <= per_q[lastx];
						dl_q[gap_q] <= dl_q[lastx]; arm_q[gap_q] <= arm_q[lastx];
						pau_q[gap_q] <= pau_q[lastx]; free_q[gap_q] <= free_q[lastx];
					end
					hnd_q[(gap_q < lastx) ? lastx : gap_q] <= '0;
					tmr_q[(gap_q < lastx) ? lastx : gap_q] <= '0;
					rep_q[(gap_q < lastx) ? lastx : gap_q] <= '0;
					per_q[(gap_q < lastx) ? lastx : gap_q] <= '0;
					dl_q[(gap_q < lastx) ? lastx : gap_q] <= '0;
					arm_q[(gap_q < lastx) ? lastx : gap_q] <= 1'b0;
					pau_q[(gap_q < lastx) ? lastx : gap_q] <= 1'b0;
					free_q[(gap_q < lastx) ? lastx : gap_q] <= 1'b1;
					if (used_q != '0) used_q <= used_q - 1'b1;
					found_q <= 1'b1;
				end
				EX_DONE: ;
				default: ;
			endcase
		end
	end
endmodule

// File: sv/timed_event_table.sv
// timed_event_table: top level, command queue, table engine, result queue
// depends on tet_pkg, tet_fifo, tet_exec
//
// channel   direction  handshake          payload
// command   in         push / full        cmd handler_id is_timer repeat_count period_ms
// result    out        pop / empty        status fired fired_handler last
// config    in         cfg_valid / ready  cfg_index cfg_data
//
// each command walks the table one slot per cycle, plus an emit state per fired handler
// and a move state per removal on run; emit waits while the result queue is full
// the command queue and the result queue let the front and the back stall apart
// reset clears the whole table at once; running starts at one
module timed_event_table import tet_pkg::*; #(
	parameter int TABLE_SIZE = 16
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [2:0] cmd,
	input logic [7:0] handler_id,
	input logic is_timer,
	input logic signed [15:0] repeat_count,
	input logic [15:0] period_ms,
	output logic empty,
	input logic pop,
	output logic [1:0] status,
	output logic fired,
	output logic [7:0] fired_handler,
	output logic last,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [15:0] cfg_data
);
	logic [15:0] thresh_q;
	logic [7:0] step_q;
	item_t in_item, q_item;
	result_t r_item, o_item;
	logic q_empty, take, rpush, rfull;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
			step_q <= STEP_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == 1'(CFG_THRESH)) thresh_q <= cfg_data;
			else step_q <= cfg_data[7:0];
		end
	end

	assign in_item = '{cmd: cmd_t'(cmd), handler_id: handler_id, is_timer: is_timer,
		repeat_count: repeat_count, period_ms: period_ms};

	tet_fifo #(.W($bits(item_t)), .DEPTH(2)) u_cq (
		.clk, .arst_n, .wr(push), .wdata(in_item), .full(full),
		.rd(take), .rdata(q_item), .empty(q_empty));

	tet_exec #(.TABLE_SIZE(TABLE_SIZE)) u_ex (
		.clk, .arst_n, .thresh(thresh_q), .step(step_q),
		.cmd_valid(!q_empty), .cmd_item(q_item), .cmd_take(take),
		.res_push(rpush), .res_item(r_item), .res_full(rfull));

	logic rq_empty;

	tet_fifo #(.W($bits(result_t)), .DEPTH(4)) u_rq (
		.clk, .arst_n, .wr(rpush), .wdata(r_item), .full(rfull),
		.rd(pop), .rdata(o_item), .empty(rq_empty));
	assign empty = rq_empty;
	assign status = o_item.status;
	assign fired = o_item.fired;
	assign fired_handler = o_item.fired_handler;
	assign last = o_item.last;

	assert property (@(posedge clk) disable iff (!arst_n) !(empty == 1'b0 && fired == 1'b0
		&& fired_handler != 8'd0)) else $error("handler without fire");
	assert property (@(posedge clk) disable iff (!arst_n) (!empty && fired) |-> status == ST_OK)
		else $error("fired beat with bad status");
endmodule

// File: verif/tb.sv
// tb: self-checking testbench for timed_event_table
// drives directed and random commands, predicts every result, checks each popped beat
// depends on tet_pkg and timed_event_table
`timescale 1ns / 100ps

module tb;
	import tet_pkg::*;

	localparam int SLOTS = 16;
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RAND_ITEMS = 470;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic [2:0] cmd;
	logic [7:0] handler_id;
	logic is_timer;
	logic signed [15:0] repeat_count;
	logic [15:0] period_ms;
	logic empty;
	logic pop;
	logic [1:0] status;
	logic fired;
	logic [7:0] fired_handler;
	logic last;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [15:0] cfg_data;

	timed_event_table uut (.*);

	typedef struct {
		item_t it;
		bit typed;
		status_t st;
	} row_t;

	// predictor state
	logic [7:0] tb_hdl [SLOTS];
	logic tb_tmr [SLOTS];
	logic [15:0] tb_rep [SLOTS];
	logic [15:0] tb_per [SLOTS];
	logic [31:0] tb_dl [SLOTS];
	logic tb_armed [SLOTS];
	logic tb_paused [SLOTS];
	logic tb_free [SLOTS];
	int used;
	logic [31:0] now_ms;
	logic running;
	logic [15:0] thresh;
	logic [7:0] step;

	result_t pending_results [$];
	row_t dir_rows [$];
	int errors = 0;
	int cycles = 0;
	bit quiet = 0;
	int pop_hold = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result checker and pop stalls
	always @(posedge clk) begin
		result_t e;
		if (pop && !empty) begin
			if (pending_results.size() == 0) begin
				$error("unexpected beat status=%0d fired=%0d handler=%0d last=%0d",
					status, fired, fired_handler, last);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (status !== e.status) begin
					$error("status exp %0d got %0d", e.status, status); errors++;
				end
				if (fired !== e.fired) begin
					$error("fired exp %0d got %0d", e.fired, fired); errors++;
				end
				if (fired_handler !== e.fired_handler) begin
					$error("fired_handler exp %0d got %0d", e.fired_handler, fired_handler);
					errors++;
				end
				if (last !== e.last) begin
					$error("last exp %0d got %0d", e.last, last); errors++;
				end
			end
		end
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (pop_hold > 0) begin
			pop_hold <= pop_hold - 1;
			pop <= 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			pop_hold <= $urandom_range(0, 14);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	function automatic void table_reset();
		for (int i = 0; i < SLOTS; i++) clear_slot(i);
		used = 0;
		now_ms = '0;
		running = 1'b1;
		thresh = THRESH_RESET;
		step = STEP_RESET;
	endfunction

	function automatic void clear_slot(int i);
		tb_hdl[i] = '0; tb_tmr[i] = 1'b0; tb_rep[i] = '0; tb_per[i] = '0;
		tb_dl[i] = '0; tb_armed[i] = 1'b0; tb_paused[i] = 1'b0; tb_free[i] = 1'b1;
	endfunction

	function automatic bit rep_positive(logic [15:0] r);
		return r != 0 && !r[15];
	endfunction

	function automatic void drop_handler(logic [7:0] h);
		int tail;
		int j;
		for (int i = 0; i < SLOTS; i++) begin
			if (tb_hdl[i] == h) begin
				tail = used > 0 ? used - 1 : 0;
				if (tail >= SLOTS) tail = SLOTS - 1;
				j = i;
				if (i < tail) begin
					tb_hdl[i] = tb_hdl[tail]; tb_tmr[i] = tb_tmr[tail];
					tb_rep[i] = tb_rep[tail]; tb_per[i] = tb_per[tail];
					tb_dl[i] = tb_dl[tail]; tb_armed[i] = tb_armed[tail];
					tb_paused[i] = tb_paused[tail]; tb_free[i] = tb_free[tail];
					j = tail;
				end
				clear_slot(j);
				if (used > 0) used--;
				return;
			end
		end
	endfunction

	function automatic status_t add_entry(item_t it);
		int i;
		logic [31:0] d;
		if (it.handler_id == 0) return ST_BAD;
		if (used + 1 >= SLOTS) return ST_FULL;
		for (i = 0; i < used && i < SLOTS; i++)
			if (tb_hdl[i] == it.handler_id && tb_armed[i]) begin
				tb_paused[i] = 1'b0;
				return ST_EXISTS;
			end
		for (i = 0; i < SLOTS; i++)
			if (tb_free[i]) break;
		if (i >= SLOTS) return ST_FULL;
		tb_hdl[i] = it.handler_id;
		tb_tmr[i] = it.is_timer;
		tb_rep[i] = it.repeat_count;
		tb_per[i] = it.period_ms;
		if (it.is_timer) begin
			d = now_ms + 32'(it.period_ms);
			if (it.period_ms > thresh) d = d + 32'(i) * 32'(step);
			tb_dl[i] = d;
			tb_armed[i] = 1'b0;
		end else begin
			tb_armed[i] = 1'b1;
		end
		tb_free[i] = 1'b0;
		tb_paused[i] = 1'b0;
		used++;
		return ST_OK;
	endfunction

	function automatic void sched_predict(item_t it, output result_t res [$]);
		status_t st;
		int i;
		int n;
		logic [7:0] fh;
		st = ST_OK;
		res = {};
		case (it.cmd)
			CMD_TICK: begin
				if (running) begin
					now_ms = now_ms + 32'd1;
					for (i = 0; i < SLOTS; i++)
						if (tb_dl[i] <= now_ms && tb_rep[i] != 0 && tb_hdl[i] != 0 &&
								tb_tmr[i] && !tb_armed[i] && !tb_paused[i]) begin
							if (rep_positive(tb_rep[i])) tb_rep[i] = tb_rep[i] - 16'd1;
							tb_dl[i] = now_ms + 32'(tb_per[i]);
							tb_armed[i] = 1'b1;
						end
				end
			end
			CMD_ADD: st = add_entry(it);
			CMD_REMOVE: begin
				if (it.handler_id == 0 || used == 0) st = ST_BAD;
				else drop_handler(it.handler_id);
			end
			CMD_PAUSE, CMD_RESUME: begin
				if (it.handler_id == 0 || used == 0) begin
					st = ST_BAD;
				end else begin
					for (i = 0; i < SLOTS; i++)
						if (tb_hdl[i] == it.handler_id) begin
							if (it.cmd == CMD_PAUSE) begin
								tb_paused[i] = 1'b1;
							end else begin
								tb_paused[i] = 1'b0;
								tb_dl[i] = 32'(tb_per[i]) + now_ms;
							end
						end
				end
			end
			CMD_RUN: begin
				n = 0;
				i = 0;
				if (running) begin
					while (i < used && i < SLOTS && n < MAX_RESULTS) begin
						if (tb_armed[i] && tb_hdl[i] != 0 && !tb_paused[i]) begin
							fh = tb_hdl[i];
							res.push_back(result_t'{ST_OK, 1'b1, fh, 1'b0});
							n++;
							if (tb_tmr[i]) begin
								if (tb_rep[i] == 0) drop_handler(fh);
								else tb_armed[i] = 1'b0;
								i++;
							end else begin
								if (rep_positive(tb_rep[i])) tb_rep[i] = tb_rep[i] - 16'd1;
								drop_handler(fh);
							end
						end else begin
							i++;
						end
					end
				end
				if (n == 0) res.push_back(result_t'{ST_OK, 1'b0, 8'd0, 1'b1});
				else res[n - 1].last = 1'b1;
				return;
			end
			CMD_HALT: running = 1'b0;
			default: running = 1'b1;
		endcase
		res.push_back(result_t'{st, 1'b0, 8'd0, 1'b1});
	endfunction

	function automatic item_t mk(cmd_t c, int h, int t, int r, int p);
		item_t it;
		it.cmd = c; it.handler_id = 8'(h); it.is_timer = 1'(t);
		it.repeat_count = 16'(r); it.period_ms = 16'(p);
		return it;
	endfunction

	function automatic void add_row(item_t it, int typed, status_t st);
		row_t r;
		r.it = it; r.typed = (typed != 0); r.st = st;
		dir_rows.push_back(r);
	endfunction

	function automatic item_t gen_item();
		item_t it;
		int k;
		k = $urandom_range(0, 99);
		if (k < 35) it.cmd = CMD_TICK;
		else if (k < 60) it.cmd = CMD_ADD;
		else if (k < 70) it.cmd = CMD_REMOVE;
		else if (k < 76) it.cmd = CMD_PAUSE;
		else if (k < 82) it.cmd = CMD_RESUME;
		else if (k < 94) it.cmd = CMD_RUN;
		else if (k < 97) it.cmd = CMD_HALT;
		else it.cmd = CMD_GO;
		it.handler_id = $urandom_range(0, 6) == 0 ? 8'($urandom) : 8'($urandom_range(1, 12));
		it.is_timer = $urandom_range(0, 2) != 0;
		it.repeat_count = $urandom_range(0, 3) == 0 ? 16'($urandom)
			: 16'($urandom_range(0, 7) - 2);
		k = $urandom_range(0, 19);
		if (k == 0) it.period_ms = 16'($urandom);
		else if (k < 5) it.period_ms = 16'($urandom_range(40, 80));
		else it.period_ms = 16'($urandom_range(0, 8));
		return it;
	endfunction

	task automatic send(item_t it, bit typed, status_t st);
		result_t res [$];
		bit go;
		push <= 1'b1;
		cmd <= it.cmd;
		handler_id <= it.handler_id;
		is_timer <= it.is_timer;
		repeat_count <= it.repeat_count;
		period_ms <= it.period_ms;
		go = 0;
		while (!go) begin
			@(negedge clk);
			go = !full;
			@(posedge clk);
		end
		sched_predict(it, res);
		if (typed) pending_results.push_back(result_t'{st, 1'b0, 8'd0, 1'b1});
		else foreach (res[j]) pending_results.push_back(res[j]);
	endtask

	task automatic sender_gap();
		int n;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 15);
			push <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic cfg_write(logic idx, logic [15:0] data);
		bit go;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		go = 0;
		while (!go) begin
			@(negedge clk);
			go = cfg_ready;
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		if (idx == 1'(CFG_THRESH)) thresh = data;
		else step = data[7:0];
	endtask

	task automatic drain();
		push <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		arst_n <= 1'b0;
		push <= 1'b0;
		cmd <= CMD_TICK;
		handler_id <= '0;
		is_timer <= 1'b0;
		repeat_count <= '0;
		period_ms <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= 1'b0;
		cfg_data <= '0;
		table_reset();

		add_row(mk(CMD_REMOVE, 8'd5, 0, 0, 0), 1, ST_BAD);
		add_row(mk(CMD_PAUSE, 8'd7, 0, 0, 0), 1, ST_BAD);
		add_row(mk(CMD_TICK, 8'd0, 0, 0, 0), 1, ST_OK);
		add_row(mk(CMD_ADD, 8'd0, 1, 16'd3, 16'd3), 1, ST_BAD);
		add_row(mk(CMD_ADD, 8'd1, 1, 16'd2, 16'd3), 1, ST_OK);
		add_row(mk(CMD_ADD, 8'd2, 0, 16'd1, 16'd0), 1, ST_OK);
		add_row(mk(CMD_ADD, 8'd2, 0, 16'd1, 16'd0), 1, ST_EXISTS);
		add_row(mk(CMD_ADD, 8'd255, 1, 16'h8000, 16'hffff), 1, ST_OK);
		add_row(mk(CMD_ADD, 8'd3, 1, 16'h7fff, 16'd0), 1, ST_OK);
		add_row(mk(CMD_RESUME, 8'd0, 0, 0, 0), 1, ST_BAD);
		add_row(mk(CMD_PAUSE, 8'd1, 0, 0, 0), 1, ST_OK);
		add_row(mk(CMD_REMOVE, 8'd99, 0, 0, 0), 1, ST_OK);
		add_row(mk(CMD_RUN, 8'd0, 0, 0, 0), 0, ST_OK);
		for (int i = 0; i < 4; i++) add_row(mk(CMD_TICK, 8'd0, 0, 0, 0), 0, ST_OK);
		add_row(mk(CMD_RESUME, 8'd1, 0, 0, 0), 1, ST_OK);
		add_row(mk(CMD_HALT, 8'd0, 0, 0, 0), 1, ST_OK);
		add_row(mk(CMD_TICK, 8'd0, 0, 0, 0), 0, ST_OK);
		add_row(mk(CMD_RUN, 8'd0, 0, 0, 0), 0, ST_OK);
		add_row(mk(CMD_GO, 8'd0, 0, 0, 0), 1, ST_OK);
		for (int i = 0; i < 3; i++) add_row(mk(CMD_TICK, 8'd0, 0, 0, 0), 0, ST_OK);
		add_row(mk(CMD_RUN, 8'd0, 0, 0, 0), 0, ST_OK);
		add_row(mk(CMD_REMOVE, 8'd255, 0, 0, 0), 1, ST_OK);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			sender_gap();
			send(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].st);
		end
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					cfg_write(1'(CFG_THRESH), 16'd0);
					cfg_write(1'(CFG_STEP), 16'd255);
				end
				1: begin
					cfg_write(1'(CFG_THRESH), 16'hffff);
					cfg_write(1'(CFG_STEP), 16'd0);
				end
				2: begin
					cfg_write(1'(CFG_THRESH), 16'($urandom_range(0, 100)));
					cfg_write(1'(CFG_STEP), 16'($urandom_range(0, 255)));
				end
				default: begin
					cfg_write(1'(CFG_THRESH), 16'(THRESH_RESET));
					cfg_write(1'(CFG_STEP), 16'(STEP_RESET));
					quiet = 1;
				end
			endcase
			for (int n = 0; n < RAND_ITEMS / 4; n++) begin
				sender_gap();
				send(gen_item(), 0, ST_OK);
			end
			drain();
		end

		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

// File: filelist.f
sv/tet_pkg.sv
sv/tet_fifo.sv
sv/tet_exec.sv
sv/timed_event_table.sv
verif/tb.sv
